// File: rtl/core/gnpm_pkg.sv
// Package for the grid nearest point matcher: shared widths, codes, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package gnpm_pkg;

   localparam int POS_W       = 14;  // 10.4 fixed-point position
   localparam int FRAC_W      = 4;
   localparam int CELL_W      = POS_W - FRAC_W;
   localparam int IN_CODE_W   = 20;
   localparam int OUT_CODE_W  = 20;
   localparam int LIMIT_W     = 16;
   localparam int RAD_W       = 3;
   localparam int OFS_W       = RAD_W + 1;   // signed window offset
   localparam int CRD_W       = 14;          // signed cell coordinate
   localparam int EPOCH_W     = 8;
   localparam int SQ_W        = 2 * POS_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int CMD_W       = 2;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_RADIUS = 1'd1;

   localparam logic [LIMIT_W-1:0] DIST_LIMIT_RST    = 16'd1024;
   localparam logic [RAD_W-1:0]   SEARCH_RADIUS_RST = 3'd2;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_wr;   // write a load transfer into its cell
      logic clear_ep;  // advance the grid epoch
      logic q_start;   // latch query, open the window
      logic scan_rd;   // read one window cell, advance the window
      logic sweep_wr;  // invalidate one cell of the sweep
      logic fin_ld;    // load the result register, free the winner cell
   } ctrl_cmd_type;

   typedef struct packed {
      logic win_last;
      logic sweep_last;
      logic epoch_last;
      logic pipe_busy;
      logic rsp_busy;
   } dp_status_type;

endpackage

// File: rtl/core/gnpm_ctrl.sv
// Controller of the grid nearest point matcher: sequences reset sweep, loads,
// clears and the window scan of a query. Depends on gnpm_pkg.
module gnpm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [gnpm_pkg::CMD_W-1:0]  req_command,
   input  logic                        req_eligible,
   input  gnpm_pkg::dp_status_type     status,
   output logic                        req_tready,
   output gnpm_pkg::ctrl_cmd_type      cmd
);
   import gnpm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_command == CMD_QUERY && req_eligible) begin
                  state_in = ST_SCAN;
               end else if (req_command == CMD_CLEAR && status.epoch_last) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SCAN: begin
            if (status.win_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_SWEEP: cmd.sweep_wr = 1'b1;
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_wr  = req_tvalid && (req_command == CMD_LOAD);
            cmd.clear_ep = req_tvalid && (req_command == CMD_CLEAR);
            cmd.q_start  = req_tvalid && (req_command == CMD_QUERY) && req_eligible;
         end
         ST_SCAN:   cmd.scan_rd = 1'b1;
         ST_DRAIN:  cmd = '0;
         ST_FINISH: cmd.fin_ld = !status.rsp_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

// File: rtl/core/gnpm_datapath.sv
// Datapath of the grid nearest point matcher: grid memory with epoch tags,
// window counters, distance pipeline, best-match registers, result register.
// Depends on gnpm_pkg; driven by gnpm_ctrl.
module gnpm_datapath #(
   parameter int GRID_W    = 1024,
   parameter int GRID_H    = 1024,
   parameter int CODE_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gnpm_pkg::ctrl_cmd_type           cmd,
   input  logic [gnpm_pkg::LIMIT_W-1:0]     dist_limit,
   input  logic [gnpm_pkg::RAD_W-1:0]       search_radius,
   input  logic [gnpm_pkg::POS_W-1:0]       req_pos_x,
   input  logic [gnpm_pkg::POS_W-1:0]       req_pos_y,
   input  logic [gnpm_pkg::IN_CODE_W-1:0]   req_point_code,
   input  logic                             req_eligible,
   input  logic                             rsp_tready,
   output gnpm_pkg::dp_status_type          status,
   output logic                             rsp_tvalid,
   output logic                             rsp_matched,
   output logic [gnpm_pkg::OUT_CODE_W-1:0]  rsp_match_code,
   output logic [gnpm_pkg::POS_W-1:0]       rsp_merged_x,
   output logic [gnpm_pkg::POS_W-1:0]       rsp_merged_y
);
   import gnpm_pkg::*;

   localparam int CELLS  = GRID_W * GRID_H;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int PT_W   = CODE_BITS + 2 * POS_W;
   localparam int ENT_W  = 1 + EPOCH_W + PT_W;

   // entry: valid, epoch, code, x, y (y in the lowest bits)
   logic [ENT_W-1:0] grid_mem [CELLS];

   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;

   logic [POS_W-1:0] q_x_ff, q_y_ff;
   logic [OFS_W-1:0] ox_ff, ox_in, oy_ff, oy_in;

   logic             s1_vld_ff, s1_ing_ff;
   logic [ENT_W-1:0] rd_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   logic                 s2_vld_ff, s2_hit_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff;
   logic [CODE_BITS-1:0] s2_code_ff;
   logic [POS_W-1:0]     s2_x_ff, s2_y_ff;
   logic [ADDR_W-1:0]    s2_addr_ff;

   logic [DIST_W-1:0]    best_d_ff;
   logic                 found_ff;
   logic [CODE_BITS-1:0] bcode_ff;
   logic [POS_W-1:0]     bx_ff, by_ff;
   logic [ADDR_W-1:0]    baddr_ff;

   logic                  rsp_vld_ff;
   logic                  rsp_match_ff;
   logic [OUT_CODE_W-1:0] rsp_code_ff;
   logic [POS_W-1:0]      rsp_mx_ff, rsp_my_ff;

   // load address
   logic [CELL_W-1:0] ld_cx, ld_cy;
   logic              ld_in_grid, ld_we;
   logic [ADDR_W-1:0] ld_addr;

   // window cell
   logic [OFS_W-1:0]  rad_ofs, rad_neg;
   logic [CRD_W-1:0]  win_x, win_y;
   logic              win_ing;
   logic [ADDR_W-1:0] rd_addr;

   // memory write port
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;

   // stage decode
   logic                 e_vld, s1_hit;
   logic [EPOCH_W-1:0]   e_epoch;
   logic [CODE_BITS-1:0] e_code;
   logic [POS_W-1:0]     e_x, e_y, adx, ady;
   logic [DIST_W-1:0]    dsum;
   logic                 upd;
   logic [POS_W:0]       sum_x, sum_y;

   assign ld_cx      = req_pos_x[POS_W-1 -: CELL_W];
   assign ld_cy      = req_pos_y[POS_W-1 -: CELL_W];
   assign ld_in_grid = (CRD_W'(ld_cx) < CRD_W'(GRID_W)) && (CRD_W'(ld_cy) < CRD_W'(GRID_H));
   assign ld_addr    = ADDR_W'(ld_cx) * ADDR_W'(GRID_H) + ADDR_W'(ld_cy);
   assign ld_we      = cmd.load_wr && req_eligible && ld_in_grid;

   assign rad_ofs = OFS_W'(search_radius);
   assign rad_neg = OFS_W'(0) - rad_ofs;

   assign win_x = CRD_W'(q_x_ff[POS_W-1 -: CELL_W]) + {{(CRD_W-OFS_W){ox_ff[OFS_W-1]}}, ox_ff};
   assign win_y = CRD_W'(q_y_ff[POS_W-1 -: CELL_W]) + {{(CRD_W-OFS_W){oy_ff[OFS_W-1]}}, oy_ff};
   assign win_ing = !win_x[CRD_W-1] && !win_y[CRD_W-1]
                 && (win_x[CRD_W-2:0] < (CRD_W-1)'(GRID_W))
                 && (win_y[CRD_W-2:0] < (CRD_W-1)'(GRID_H));
   assign rd_addr = win_ing ? ADDR_W'(win_x[CRD_W-2:0]) * ADDR_W'(GRID_H)
                              + ADDR_W'(win_y[CRD_W-2:0])
                            : '0;

   assign status.win_last   = (ox_ff == rad_ofs) && (oy_ff == rad_ofs);
   assign status.sweep_last = (sweep_ff == ADDR_W'(CELLS - 1));
   assign status.epoch_last = &epoch_ff;
   assign status.pipe_busy  = s1_vld_ff || s2_vld_ff;
   assign status.rsp_busy   = rsp_vld_ff && !rsp_tready;

   // one write port: sweep, load, free the winner cell
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ld_addr;
      mem_wdata = {1'b1, epoch_ff, CODE_BITS'(req_point_code), req_pos_x, req_pos_y};
      priority if (cmd.sweep_wr) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = '0;
      end else if (ld_we) begin
         mem_we = 1'b1;
      end else if (cmd.fin_ld && found_ff) begin
         mem_we    = 1'b1;
         mem_waddr = baddr_ff;
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) rd_ff <= grid_mem[rd_addr];
   end

   // sweep counter and epoch
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_wr) sweep_in = status.sweep_last ? '0 : sweep_ff + 1'b1;
      epoch_in = epoch_ff;
      if (cmd.clear_ep) epoch_in = epoch_ff + 1'b1;
   end

   // window offsets, y inner
   always_comb begin
      ox_in = ox_ff;
      oy_in = oy_ff;
      if (cmd.q_start) begin
         ox_in = rad_neg;
         oy_in = rad_neg;
      end else if (cmd.scan_rd) begin
         if (oy_ff == rad_ofs) begin
            oy_in = rad_neg;
            ox_in = ox_ff + 1'b1;
         end else begin
            oy_in = oy_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff   <= '0;
         epoch_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         sweep_ff  <= sweep_in;
         epoch_ff  <= epoch_in;
         s1_vld_ff <= cmd.scan_rd;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.q_start) begin
            found_ff <= 1'b0;
         end else if (upd) begin
            found_ff <= 1'b1;
         end
         if (cmd.fin_ld) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // stage 1 decode: read entry, check tag, distance terms
   assign e_vld   = rd_ff[ENT_W-1];
   assign e_epoch = rd_ff[ENT_W-2 -: EPOCH_W];
   assign e_code  = rd_ff[2*POS_W +: CODE_BITS];
   assign e_x     = rd_ff[POS_W +: POS_W];
   assign e_y     = rd_ff[0 +: POS_W];
   assign s1_hit  = s1_vld_ff && s1_ing_ff && e_vld && (e_epoch == epoch_ff);
   assign adx     = (e_x > q_x_ff) ? e_x - q_x_ff : q_x_ff - e_x;
   assign ady     = (e_y > q_y_ff) ? e_y - q_y_ff : q_y_ff - e_y;

   // stage 3: strict compare keeps the first point on ties
   assign dsum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign upd  = s2_vld_ff && s2_hit_ff && (dsum < best_d_ff);

   assign sum_x = (POS_W+1)'(q_x_ff) + (POS_W+1)'(bx_ff);
   assign sum_y = (POS_W+1)'(q_y_ff) + (POS_W+1)'(by_ff);

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         q_x_ff    <= req_pos_x;
         q_y_ff    <= req_pos_y;
         best_d_ff <= DIST_W'(dist_limit);
      end else if (upd) begin
         best_d_ff <= dsum;
      end
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      if (cmd.scan_rd) begin
         s1_ing_ff  <= win_ing;
         s1_addr_ff <= rd_addr;
      end
      s2_hit_ff  <= s1_hit;
      sqx_ff     <= SQ_W'(adx) * SQ_W'(adx);
      sqy_ff     <= SQ_W'(ady) * SQ_W'(ady);
      s2_code_ff <= e_code;
      s2_x_ff    <= e_x;
      s2_y_ff    <= e_y;
      s2_addr_ff <= s1_addr_ff;
      if (upd) begin
         bcode_ff <= s2_code_ff;
         bx_ff    <= s2_x_ff;
         by_ff    <= s2_y_ff;
         baddr_ff <= s2_addr_ff;
      end
      if (cmd.fin_ld) begin
         rsp_match_ff <= found_ff;
         rsp_code_ff  <= found_ff ? OUT_CODE_W'(bcode_ff) : '0;
         rsp_mx_ff    <= found_ff ? sum_x[POS_W:1] : q_x_ff;
         rsp_my_ff    <= found_ff ? sum_y[POS_W:1] : q_y_ff;
      end
   end

   assign rsp_tvalid     = rsp_vld_ff;
   assign rsp_matched    = rsp_match_ff;
   assign rsp_match_code = rsp_code_ff;
   assign rsp_merged_x   = rsp_mx_ff;
   assign rsp_merged_y   = rsp_my_ff;

endmodule

// File: rtl/core/grid_nearest_point_matcher.sv
// Grid nearest point matcher, top level: stream ports, configuration
// registers, controller and datapath. Depends on gnpm_pkg, gnpm_ctrl,
// gnpm_datapath.
//
// Usage: req_ carries commands (tuser): load a point into the grid cell under
// it, query the nearest stored point, or clear the grid. Only an eligible
// query returns a transfer on rsp_: matched flag (tuser), code and averaged
// position; the winning cell is emptied.
// A query with search radius r reads a window of (2r+1)^2 cells, one cell per
// cycle through the single read port of the grid memory, then a three-stage
// distance pipeline drains.
// Cells carry an epoch tag, so a clear only advances the epoch; every 256th
// clear wraps it and starts a sweep that empties all GRID_W*GRID_H cells, one
// per cycle. The same sweep runs after reset; req_tready stays low during it.
// The result sits in an output register: the block accepts further requests
// while it waits; a query that finishes while rsp_ is still stalled holds until
// the pending result is taken. csr_ writes are taken any cycle.
module grid_nearest_point_matcher #(
   parameter int GRID_W    = 1024,
   parameter int GRID_H    = 1024,
   parameter int CODE_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x[13:0], pos_y[27:14], point_code[47:28], eligible[48], zero pad
   input  logic [gnpm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // command[1:0]
   input  logic [gnpm_pkg::CMD_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // match_code[19:0], merged_x[33:20], merged_y[47:34]
   output logic [gnpm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // matched[0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [gnpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gnpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gnpm_pkg::*;

   logic [LIMIT_W-1:0] dist_limit_ff;
   logic [RAD_W-1:0]   radius_ff;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic [POS_W-1:0]      req_pos_x, req_pos_y;
   logic [IN_CODE_W-1:0]  req_point_code;
   logic                  req_eligible;
   logic [OUT_CODE_W-1:0] rsp_match_code;
   logic [POS_W-1:0]      rsp_merged_x, rsp_merged_y;

   assign req_pos_x      = req_tdata[0 +: POS_W];
   assign req_pos_y      = req_tdata[POS_W +: POS_W];
   assign req_point_code = req_tdata[2*POS_W +: IN_CODE_W];
   assign req_eligible   = req_tdata[2*POS_W + IN_CODE_W];

   assign rsp_tdata = {rsp_merged_y, rsp_merged_x, rsp_match_code};

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_limit_ff <= DIST_LIMIT_RST;
         radius_ff     <= SEARCH_RADIUS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIST_LIMIT:    dist_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_SEARCH_RADIUS: radius_ff     <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   gnpm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_command  (req_tuser),
      .req_eligible (req_eligible),
      .status       (status),
      .req_tready   (req_tready),
      .cmd          (cmd)
   );

   gnpm_datapath #(
      .GRID_W    (GRID_W),
      .GRID_H    (GRID_H),
      .CODE_BITS (CODE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dist_limit     (dist_limit_ff),
      .search_radius  (radius_ff),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_point_code (req_point_code),
      .req_eligible   (req_eligible),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_matched    (rsp_tuser),
      .rsp_match_code (rsp_match_code),
      .rsp_merged_x   (rsp_merged_x),
      .rsp_merged_y   (rsp_merged_y)
   );

   // no request is taken while the window is being read
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> !req_tready)
      else $error("request accepted during window scan");

   // a result appears only after the controller loaded it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.fin_ld))
      else $error("result raised without a finished query");

   // a pending stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.fin_ld |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while stalled");

endmodule

// File: sim/tb_grid_nearest_point_matcher.sv
// Testbench for grid_nearest_point_matcher: sends load, query and clear transfers,
// predicts every query result from a sparse copy of the grid and checks the
// result stream field by field. Depends on gnpm_pkg and the RTL top level.
module tb_grid_nearest_point_matcher;
   timeunit 1ns;
   timeprecision 1ps;
   import gnpm_pkg::*;

   localparam int GRID_W = 1024;
   localparam int GRID_H = 1024;
   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   // worst query has search radius 7, plus one held result
   localparam int QUIET_CYCLES = 300;
   // the reset sweep keeps req_tready low while it empties all GRID_W*GRID_H cells
   localparam int WATCHDOG_LIMIT = 4_500_000;
   localparam int CHUNK_ITEMS = 125;
   localparam int REQ_PAD_W = REQ_TDATA_W - 1 - IN_CODE_W - 2 * POS_W;

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      logic [IN_CODE_W-1:0] code;
      pos_type              x;
      pos_type              y;
   } grid_point_type;

   typedef struct packed {
      logic                  matched;
      logic [OUT_CODE_W-1:0] code;
      pos_type               x;
      pos_type               y;
   } match_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = CMD_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_DIST_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   grid_point_type     grid_points [int unsigned];
   match_result_type   pending_matches [$];
   logic [LIMIT_W-1:0] model_limit = DIST_LIMIT_RST;
   logic [RAD_W-1:0]   model_radius = SEARCH_RADIUS_RST;
   int                 tx_idle_pct = 26;
   int                 rx_idle_pct = 51;
   int                 work_items = 0;
   int                 errors = 0;

   always #6 clock = ~clock;

   grid_nearest_point_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Update the grid copy for one accepted command; queue the query result.
   function automatic void predict_match(logic [CMD_W-1:0] cmd, pos_type px, pos_type py,
                                         logic [IN_CODE_W-1:0] code, logic elig);
      int               cx, cy, r, xi, yi, dx, dy, sq_dist, best;
      int unsigned      idx, best_idx;
      bit               found;
      grid_point_type   hit;
      match_result_type res;
      cx = int'(px) >> FRAC_W;
      cy = int'(py) >> FRAC_W;
      case (cmd)
         CMD_CLEAR: grid_points.delete();
         CMD_LOAD: begin
            if (elig && cx < GRID_W && cy < GRID_H)
               grid_points[cx * GRID_H + cy] = '{code, px, py};
         end
         CMD_QUERY: begin
            if (elig) begin
               r = int'(model_radius);
               best = int'(model_limit);
               found = 1'b0;
               best_idx = 0;
               // x outer, y inner; only a strictly nearer point replaces the best
               for (xi = cx - r; xi <= cx + r; xi++) begin
                  for (yi = cy - r; yi <= cy + r; yi++) begin
                     if (xi < 0 || xi >= GRID_W || yi < 0 || yi >= GRID_H)
                        continue;
                     idx = xi * GRID_H + yi;
                     if (!grid_points.exists(idx))
                        continue;
                     hit = grid_points[idx];
                     dx = int'(hit.x) - int'(px);
                     dy = int'(hit.y) - int'(py);
                     sq_dist = dx * dx + dy * dy;
                     if (sq_dist < best) begin
                        best = sq_dist;
                        best_idx = idx;
                        found = 1'b1;
                     end
                  end
               end
               if (found) begin
                  hit = grid_points[best_idx];
                  grid_points.delete(best_idx);
                  res.matched = 1'b1;
                  res.code = hit.code;
                  res.x = pos_type'((int'(px) + int'(hit.x)) >> 1);
                  res.y = pos_type'((int'(py) + int'(hit.y)) >> 1);
               end else begin
                  res = '{1'b0, '0, px, py};
               end
               pending_matches = {pending_matches, res};
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(logic [CMD_W-1:0] cmd, pos_type px, pos_type py,
                            logic [IN_CODE_W-1:0] code, logic elig);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{REQ_PAD_W{1'b0}}, elig, code, py, px};
      do @(posedge clock); while (!req_tready);
      predict_match(cmd, px, py, code, elig);
      if (cmd == CMD_CLEAR || (elig && (cmd == CMD_LOAD || cmd == CMD_QUERY)))
         work_items++;
   endtask

   // Hold the request side until every result is in and the block is quiet.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DIST_LIMIT)
         model_limit = value;
      else
         model_radius = value[RAD_W-1:0];
   endtask

   task automatic configure(int limit, int radius);
      drain_results();
      write_csr(CSR_DIST_LIMIT, CSR_DATA_W'(limit));
      write_csr(CSR_SEARCH_RADIUS, CSR_DATA_W'(radius));
   endtask

   function automatic pos_type near(int center, int span);
      int v;
      v = center + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0)
         v = 0;
      if (v > POS_MAX)
         v = POS_MAX;
      return pos_type'(v);
   endfunction

   // Mostly anywhere, sometimes hugging either edge of the grid.
   function automatic int pick_center();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 60);
         1: return POS_MAX - $urandom_range(0, 60);
         default: return $urandom_range(0, POS_MAX);
      endcase
   endfunction

   // Runs with the reset values of the registers.
   task automatic test_directed();
      send_item(CMD_QUERY, 100, 100, 20'h0F0F0, 1'b1);   // empty grid
      send_item(CMD_LOAD, 0, 0, 20'h00000, 1'b1);
      send_item(CMD_LOAD, POS_MAX, POS_MAX, 20'hFFFFF, 1'b1);
      send_item(CMD_QUERY, 0, 0, 20'h00000, 1'b1);       // window past low edges
      send_item(CMD_QUERY, POS_MAX, POS_MAX, 20'hFFFFF, 1'b1);
      send_item(CMD_QUERY, 0, 0, 20'h00000, 1'b1);       // winner cell was emptied
      send_item(CMD_LOAD, 320, 320, 20'h12345, 1'b0);    // ineligible load dropped
      send_item(CMD_QUERY, 320, 320, 20'h00001, 1'b1);
      send_item(CMD_QUERY, 320, 320, 20'h00002, 1'b0);   // ineligible query, silent
      send_item(CMD_RESERVED, 320, 320, 20'hABCDE, 1'b1);
      send_item(CMD_LOAD, 480, 480, 20'hAAAAA, 1'b1);
      send_item(CMD_LOAD, 490, 485, 20'h55555, 1'b1);    // overwrite same cell
      send_item(CMD_QUERY, 480, 480, 20'h00003, 1'b1);
      // equal distance on both sides: the lower x cell is scanned first
      send_item(CMD_LOAD, 144, 160, 20'h00001, 1'b1);
      send_item(CMD_LOAD, 176, 160, 20'h00002, 1'b1);
      send_item(CMD_QUERY, 160, 160, 20'h00004, 1'b1);
      send_item(CMD_QUERY, 160, 160, 20'h00005, 1'b1);
      send_item(CMD_LOAD, 800, 800, 20'h00003, 1'b1);
      send_item(CMD_CLEAR, 0, 0, 20'h00000, 1'b0);
      send_item(CMD_QUERY, 800, 800, 20'h00006, 1'b1);
      // later but nearer point wins
      send_item(CMD_LOAD, 640, 640, 20'h00004, 1'b1);
      send_item(CMD_LOAD, 672, 660, 20'h00005, 1'b1);
      send_item(CMD_QUERY, 660, 650, 20'h00007, 1'b1);
      // distance equal to the limit is no match
      send_item(CMD_LOAD, 1000, 1000, 20'h00006, 1'b1);
      send_item(CMD_QUERY, 1032, 1000, 20'h00008, 1'b1);
   endtask

   task automatic test_random_traffic();
      int limit_set [6] = '{1024, 65535, 0, 4000, 65535, 200};
      int radius_set [6] = '{2, 7, 3, 0, 1, 7};
      int k, target, cx, cy, span, n;
      logic [CMD_W-1:0] cmd;
      for (int ph = 0; ph < 3; ph++) begin
         for (int c = 0; c < 4; c++) begin
            k = ph * 4 + c;
            if (k < 6)
               configure(limit_set[k], radius_set[k]);
            else
               configure($urandom_range(0, 65535), $urandom_range(0, 7));
            case (ph)
               0: begin tx_idle_pct = 26; rx_idle_pct = 51; end
               1: begin tx_idle_pct = 51; rx_idle_pct = 26; end
               default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            target = work_items + CHUNK_ITEMS;
            while (work_items < target) begin
               if ($urandom_range(99) < 15) begin
                  cmd = CMD_W'($urandom_range(0, 3));
                  if (cmd == CMD_CLEAR && $urandom_range(3) != 0)
                     cmd = CMD_RESERVED;
                  send_item(cmd, pos_type'($urandom_range(0, POS_MAX)),
                            pos_type'($urandom_range(0, POS_MAX)),
                            IN_CODE_W'($urandom_range(0, 20'hFFFFF)),
                            1'($urandom_range(0, 1)));
               end else if ($urandom_range(99) == 0) begin
                  send_item(CMD_CLEAR, pos_type'($urandom_range(0, POS_MAX)),
                            pos_type'($urandom_range(0, POS_MAX)),
                            IN_CODE_W'($urandom_range(0, 20'hFFFFF)),
                            1'($urandom_range(0, 1)));
               end else begin
                  // a few loads around one spot, then queries close to it
                  cx = pick_center();
                  cy = pick_center();
                  span = (int'(model_radius) + 1) * 16;
                  n = $urandom_range(1, 6);
                  repeat (n)
                     send_item(CMD_LOAD, near(cx, span), near(cy, span),
                               IN_CODE_W'($urandom_range(0, 20'hFFFFF)),
                               $urandom_range(9) != 0);
                  n = $urandom_range(1, 4);
                  repeat (n)
                     send_item(CMD_QUERY, near(cx, 24), near(cy, 24),
                               IN_CODE_W'($urandom_range(0, 20'hFFFFF)),
                               $urandom_range(9) != 0);
               end
            end
         end
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      match_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual code 0x%0h",
                     $time, rsp_tdata[OUT_CODE_W-1:0]);
            errors++;
         end else begin
            want = pending_matches.pop_front();
            check_field("matched", want.matched, rsp_tuser);
            check_field("match_code", want.code, rsp_tdata[19:0]);
            check_field("merged_x", want.x, rsp_tdata[33:20]);
            check_field("merged_y", want.y, rsp_tdata[47:34]);
         end
      end
   end

   // Count cycles without any transfer on either stream.
   initial begin
      int quiet_count;
      quiet_count = 0;
      while (quiet_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_count = 0;
         else
            quiet_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      drain_results();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
